### rtl/core/mfbs_pkg.sv
// ============================================================================
// mfbs_pkg
// Shared widths, register indexes, state type and the percent-to-factor
// table for the motion friction/bounce step block.
// ============================================================================
package mfbs_pkg;

    // Field widths
    localparam int VEL_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int MODE_W     = 2;
    localparam int PCT_W      = 7;
    localparam int PCT_LEVELS = 1 << PCT_W;
    localparam int FACTOR_W   = 17;   // (127 << 16) / 100 fits in 17 bits
    localparam int PCT_DIV    = 100;
    localparam int FRAC_SHIFT = 16;

    // Velocity limits
    localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sd32767;
    localparam logic signed [VEL_W-1:0] VEL_MIN = -16'sd32767;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = PCT_W;
    localparam logic [CFG_INDEX_W-1:0] REG_FRICTION   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ELASTICITY = 1'd1;

    // Step modes
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD       = 2'd0,
        MODE_FRICTION   = 2'd1,
        MODE_BOUNCE_V   = 2'd2,
        MODE_BOUNCE_H   = 2'd3
    } mode_t;

    // Motion state carried from step to step
    typedef struct packed {
        logic signed [VEL_W-1:0] vel_h;
        logic signed [VEL_W-1:0] vel_v;
        logic [FRAC_W-1:0]       frac;
    } mfbs_state_t;

    // Percent to 16.16 scale factor, (pct << 16) / 100
    typedef logic [FACTOR_W-1:0] factor_lut_t [PCT_LEVELS];

    function automatic factor_lut_t build_factor_lut();
        factor_lut_t lut;
        for (int i = 0; i < PCT_LEVELS; i++)
        begin
            lut[i] = FACTOR_W'((i << FRAC_SHIFT) / PCT_DIV);
        end
        return lut;
    endfunction

    localparam factor_lut_t FACTOR_LUT = build_factor_lut();

endpackage

### rtl/core/mfbs_if.sv
// ============================================================================
// mfbs_in_if / mfbs_out_if
// Valid/ready channels for step commands and velocity results.
// ============================================================================
interface mfbs_in_if
    import mfbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [VEL_W-1:0] load_h;
    logic signed [VEL_W-1:0] load_v;

    modport source  (output valid, output mode, output load_h, output load_v, input ready);
    modport sink    (input valid, input mode, input load_h, input load_v, output ready);
    modport monitor (input valid, input mode, input load_h, input load_v, input ready);
endinterface

interface mfbs_out_if
    import mfbs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] speed_h;
    logic signed [VEL_W-1:0] speed_v;

    modport source  (output valid, output speed_h, output speed_v, input ready);
    modport sink    (input valid, input speed_h, input speed_v, output ready);
    modport monitor (input valid, input speed_h, input speed_v, input ready);
endinterface

### rtl/core/motion_friction_bounce_step.sv
// ============================================================================
// motion_friction_bounce_step
// Horizontal/vertical velocity with friction ticks and elastic bounces.
// ============================================================================
// Takes one step command per cycle and returns one result per command with
// both velocities after that step. A command is captured in an input
// register; once the result slot is free or drains, its new state is
// computed through one shared 17x18 multiplier and written to the state
// register, which is also the result register. Throughput is one command
// per clock as long as the result side takes results; a stalled result
// holds the pipe with one command waiting in the input register. Percent
// registers are converted to 16.16 factors when written and should only be
// written while no command is in flight.
module motion_friction_bounce_step
    import mfbs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    mfbs_in_if.sink                step_in,
    mfbs_out_if.source             step_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);
    logic                    in_valid_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [VEL_W-1:0] load_h_reg;
    logic signed [VEL_W-1:0] load_v_reg;
    logic                    out_valid_reg;
    logic [FACTOR_W-1:0]     fric_factor_reg;
    logic [FACTOR_W-1:0]     elas_factor_reg;
    mfbs_state_t             state_reg;
    mfbs_state_t             state_next;
    logic                    advance;

    // Move the input stage forward when the result slot is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || step_out.ready);
    assign step_in.ready = !in_valid_reg || advance;

    // Configuration: store the scale factor for each percent register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fric_factor_reg <= '0;
            elas_factor_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRICTION:   fric_factor_reg <= FACTOR_LUT[cfg_data];
                REG_ELASTICITY: elas_factor_reg <= FACTOR_LUT[cfg_data];
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (step_in.ready)
            in_valid_reg <= step_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step_in.valid && step_in.ready)
        begin
            mode_reg   <= step_in.mode;
            load_h_reg <= step_in.load_h;
            load_v_reg <= step_in.load_v;
        end
    end

    // Step logic
    mfbs_step u_step (
        .mode              (mode_reg),
        .load_h            (load_h_reg),
        .load_v            (load_v_reg),
        .friction_factor   (fric_factor_reg),
        .elasticity_factor (elas_factor_reg),
        .cur               (state_reg),
        .nxt               (state_next)
    );

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (step_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign step_out.valid   = out_valid_reg;
    assign step_out.speed_h = state_reg.vel_h;
    assign step_out.speed_v = state_reg.vel_v;

endmodule

### rtl/core/mfbs_step.sv
// ============================================================================
// mfbs_step
// Next-state logic for one step: load, friction tick or bounce, sharing a
// single signed multiplier between the friction and bounce paths.
// ============================================================================
module mfbs_step
    import mfbs_pkg::*;
(
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [VEL_W-1:0] load_h,
    input  logic signed [VEL_W-1:0] load_v,
    input  logic [FACTOR_W-1:0]     friction_factor,
    input  logic [FACTOR_W-1:0]     elasticity_factor,
    input  mfbs_state_t             cur,
    output mfbs_state_t             nxt
);
    localparam int OP_W   = VEL_W + 1;
    localparam int FAC_W  = FACTOR_W + 1;
    localparam int PROD_W = OP_W + FAC_W;
    localparam int ACC_W  = 2 * FRAC_W + 1;
    localparam int WHOLE_W = ACC_W - FRAC_SHIFT;
    localparam int R_W    = PROD_W - FRAC_SHIFT;

    mode_t                     step_mode;
    logic signed [VEL_W-1:0]   bounce_src;
    logic signed [OP_W-1:0]    neg_ext;
    logic [VEL_W-1:0]          mag;
    logic signed [OP_W-1:0]    mul_a;
    logic signed [FAC_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [ACC_W-1:0]          acc;
    logic [WHOLE_W-1:0]        whole;
    logic signed [VEL_W-1:0]   fric_vel;
    logic signed [R_W-1:0]     r_raw;
    logic signed [R_W-1:0]     r_adj;
    logic signed [R_W-1:0]     neg_r;
    logic signed [VEL_W-1:0]   bounce_vel;

    assign step_mode = mode_t'(mode);

    // Pick the velocity to bounce and its negation
    assign bounce_src = (step_mode == MODE_BOUNCE_V) ? cur.vel_v : cur.vel_h;
    assign neg_ext    = -OP_W'(bounce_src);
    assign mag        = cur.vel_h[VEL_W-1] ? VEL_W'(-cur.vel_h) : cur.vel_h;

    // Shared multiplier: |vel_h| * friction or -vel * elasticity
    assign mul_a = (step_mode == MODE_FRICTION) ? $signed({1'b0, mag}) : neg_ext;
    assign mul_b = (step_mode == MODE_FRICTION) ? $signed({1'b0, friction_factor})
                                                : $signed({1'b0, elasticity_factor});
    assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Friction: add carried remainder, remove whole part toward zero
    assign acc   = ACC_W'(cur.frac) + ACC_W'(prod[ACC_W-2:0]);
    assign whole = acc[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (whole >= WHOLE_W'(mag))
            fric_vel = '0;
        else if (cur.vel_h[VEL_W-1])
            fric_vel = cur.vel_h + $signed(whole[VEL_W-1:0]);
        else
            fric_vel = cur.vel_h - $signed(whole[VEL_W-1:0]);
    end

    // Bounce: floor shift, nudge an unchanged result, then saturate
    assign r_raw = prod[PROD_W-1:FRAC_SHIFT];
    assign neg_r = R_W'(neg_ext);

    always_comb
    begin
        if (r_raw == neg_r)
        begin
            if (r_raw > 0)
                r_adj = r_raw - R_W'(1);
            else
                r_adj = r_raw + R_W'(1);
        end
        else
        begin
            r_adj = r_raw;
        end

        if (r_adj > R_W'(VEL_MAX))
            bounce_vel = VEL_MAX;
        else if (r_adj < R_W'(VEL_MIN))
            bounce_vel = VEL_MIN;
        else
            bounce_vel = r_adj[VEL_W-1:0];
    end

    // Select the new state by mode
    always_comb
    begin
        nxt = cur;
        case (step_mode)
            MODE_LOAD:
            begin
                nxt.vel_h = (load_h == -16'sd32768) ? VEL_MIN : load_h;
                nxt.vel_v = (load_v == -16'sd32768) ? VEL_MIN : load_v;
            end
            MODE_FRICTION:
            begin
                if (cur.vel_h != '0)
                begin
                    nxt.vel_h = fric_vel;
                    nxt.frac  = acc[FRAC_W-1:0];
                end
            end
            MODE_BOUNCE_V:
            begin
                nxt.vel_v = bounce_vel;
            end
            MODE_BOUNCE_H:
            begin
                nxt.vel_h = bounce_vel;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### rtl/core/mfbs_checker.sv
// ============================================================================
// mfbs_checker
// Port-level checks for the motion step block, bound to the top level.
// ============================================================================
module mfbs_checker
    import mfbs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic signed [VEL_W-1:0] speed_h,
    input  logic signed [VEL_W-1:0] speed_v
);

    // Hold a stalled result unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(speed_h) && $stable(speed_v))
    else $error("stalled result changed or dropped");

    // Velocities stay within the symmetric range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed_h != -16'sd32768)
    else $error("speed_h out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed_v != -16'sd32768)
    else $error("speed_v out of range");

    // An empty result slot never blocks new commands
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

endmodule

bind motion_friction_bounce_step mfbs_checker u_mfbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (step_in.valid),
    .in_ready  (step_in.ready),
    .out_valid (step_out.valid),
    .out_ready (step_out.ready),
    .speed_h   (step_out.speed_h),
    .speed_v   (step_out.speed_v)
);
